>>> rtl/isrt_pkg.sv
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared constants and types for the insertion sorter.
// ----------------------------------------------------------------------------
package isrt_pkg;

   // default store capacity in keys
   localparam int MAX_LEN_DEF = 64;

   // key width
   localparam int KEY_W = 32;

   // result register control handed from sequencer to output stage
   typedef struct packed {
      logic load;
      logic last;
      logic ovf;
   } isrt_emit_type;

endpackage

>>> rtl/isrt_store.sv
// ----------------------------------------------------------------------------
// isrt_store
// Sorted key memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module isrt_store #(
   parameter int MAX_LEN = isrt_pkg::MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(MAX_LEN)-1:0] wr_addr,
   input  logic [isrt_pkg::KEY_W-1:0] wr_data,
   input  logic [$clog2(MAX_LEN)-1:0] rd_addr,
   output logic [isrt_pkg::KEY_W-1:0] rd_data
);
   import isrt_pkg::*;

   logic [KEY_W-1:0] mem [MAX_LEN];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/isrt_seq.sv
// ----------------------------------------------------------------------------
// isrt_seq
// Insertion sequencer: walks the store from the top, one compare and one
// shift per cycle, then reads the batch out in order.
// ----------------------------------------------------------------------------
module isrt_seq #(
   parameter int MAX_LEN = isrt_pkg::MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input word
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [isrt_pkg::KEY_W-1:0]    req_tdata,
   input  logic                          req_tlast,
   // store access
   output logic                          wr_en,
   output logic [$clog2(MAX_LEN)-1:0]    wr_addr,
   output logic [isrt_pkg::KEY_W-1:0]    wr_data,
   output logic [$clog2(MAX_LEN)-1:0]    rd_addr,
   input  logic [isrt_pkg::KEY_W-1:0]    rd_data,
   // output stage
   output isrt_pkg::isrt_emit_type       emit,
   input  logic                          rsp_done
);
   import isrt_pkg::*;

   localparam int AW    = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SHIFT     = 3'd1;
   localparam logic [2:0] S_PLACE     = 3'd2;
   localparam logic [2:0] S_EMIT_RD   = 3'd3;
   localparam logic [2:0] S_EMIT_LD   = 3'd4;
   localparam logic [2:0] S_EMIT_WAIT = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             batch_end_ff, batch_end_in;

   logic [CNT_W-1:0] fill_m1;
   logic [CNT_W-1:0] pos_m1;
   logic [CNT_W-1:0] pos_m2;
   logic [CNT_W-1:0] idx_p1;
   logic             key_lt;
   logic             idx_is_last;

   assign fill_m1     = fill_ff - CNT_W'(1);
   assign pos_m1      = pos_ff - CNT_W'(1);
   assign pos_m2      = pos_ff - CNT_W'(2);
   assign idx_p1      = idx_ff + CNT_W'(1);
   assign idx_is_last = (idx_p1 == fill_ff);

   // compare unit: new key strictly below the stored key, both signed
   assign key_lt = ($signed(key_ff) < $signed(rd_data));

   // next state and store access
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      batch_end_in = batch_end_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      wr_data      = key_ff;
      rd_addr      = idx_ff[AW-1:0];
      emit         = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            // prefetch the top stored key
            rd_addr    = fill_m1[AW-1:0];
            if (req_tvalid) begin
               key_in       = req_tdata;
               batch_end_in = req_tlast;
               idx_in       = '0;
               if (fill_ff == CNT_W'(MAX_LEN)) begin
                  dropped_in = 1'b1;
                  state_in   = req_tlast ? S_EMIT_RD : S_IDLE;
               end else if (fill_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_tdata;
                  fill_in  = fill_ff + CNT_W'(1);
                  state_in = req_tlast ? S_EMIT_RD : S_IDLE;
               end else begin
                  pos_in   = fill_ff;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            wr_en = 1'b1;
            if (key_lt) begin
               // move the larger key up one place and fetch the next one down
               wr_addr = pos_ff[AW-1:0];
               wr_data = rd_data;
               pos_in  = pos_m1;
               rd_addr = pos_m2[AW-1:0];
               if (pos_ff == CNT_W'(1)) begin
                  state_in = S_PLACE;
               end
            end else begin
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = key_ff;
               fill_in  = fill_ff + CNT_W'(1);
               state_in = batch_end_ff ? S_EMIT_RD : S_IDLE;
            end
         end
         S_PLACE: begin
            // new key is the smallest so far
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = key_ff;
            fill_in  = fill_ff + CNT_W'(1);
            state_in = batch_end_ff ? S_EMIT_RD : S_IDLE;
         end
         S_EMIT_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            emit.load = 1'b1;
            emit.last = idx_is_last;
            emit.ovf  = dropped_ff;
            state_in  = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_done) begin
               if (idx_is_last) begin
                  fill_in    = '0;
                  dropped_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  idx_in   = idx_p1;
                  rd_addr  = idx_p1[AW-1:0];
                  state_in = S_EMIT_LD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      key_ff       <= key_in;
      batch_end_ff <= batch_end_in;
   end

   // fill count never passes capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_LEN))
      else $error("fill count above capacity");

   // shift pointer stays between 1 and the fill count, with the store not full
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> (pos_ff != '0) && (pos_ff <= fill_ff) &&
                              (fill_ff < CNT_W'(MAX_LEN)))
      else $error("shift pointer out of range");

   // the final word of a batch empties the store
   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_WAIT) && rsp_done && idx_is_last |=>
         (fill_ff == '0) && !dropped_ff && (state_ff == S_IDLE))
      else $error("store not emptied after batch");

endmodule

>>> rtl/insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// insertion_sorter_top
// Stable ascending insertion sorter for signed 32-bit keys.
// ----------------------------------------------------------------------------
// Keys are inserted one at a time into a sorted memory of MAX_LEN entries;
// equal keys keep their arrival order. The memory moves each stored key
// that is larger than the new one up one place per cycle while the
// comparator checks the next one down; a key that arrives with the store
// full is dropped, and one that arrives into an empty store is written
// straight to the bottom entry. req_tready is high only between keys.
// A key with req_tlast set is inserted (or dropped when the store is full)
// and then the whole batch is streamed out smallest first, one word at a
// time, each after the previous one is taken, with rsp_tlast on the final
// word and rsp_tuser set on every word when keys were dropped for capacity.
// The store then empties; no clearing pass is needed after reset.
module insertion_sorter_top #(
   parameter int MAX_LEN = isrt_pkg::MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // input words
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [isrt_pkg::KEY_W-1:0] req_tdata,   // [31:0] key
   input  logic                       req_tlast,   // last_in
   // result words
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [isrt_pkg::KEY_W-1:0] rsp_tdata,   // [31:0] sorted_key
   output logic                       rsp_tlast,   // last_out
   output logic [0:0]                 rsp_tuser    // [0] overflow
);
   import isrt_pkg::*;

   localparam int AW = $clog2(MAX_LEN);

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr;
   logic [KEY_W-1:0] rd_data;
   isrt_emit_type    emit;
   logic             rsp_done;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] rsp_data_ff;
   logic             rsp_last_ff;
   logic             rsp_ovf_ff;

   // sorted key memory
   isrt_store #(
      .MAX_LEN (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // insertion and read-out sequencer
   isrt_seq #(
      .MAX_LEN (MAX_LEN)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .emit       (emit),
      .rsp_done   (rsp_done)
   );

   // output word register
   assign rsp_done = rsp_valid_ff & rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_done) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_data_ff <= rd_data;
         rsp_last_ff <= emit.last;
         rsp_ovf_ff  <= emit.ovf;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the insertion sorter. Batches of signed keys go in
// on the req stream and each one ends on a word with req_tlast. A scoreboard
// keeps its own sorted copy of every batch. It checks each sorted word that
// comes back, with its last and overflow flags. Both streams idle and stall
// at random. The batches range from a single key to runs past the store's
// capacity.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STORE_DEPTH   = isrt_pkg::MAX_LEN_DEF;
   localparam int KEY_W         = isrt_pkg::KEY_W;
   localparam int RANDOM_KEYS   = 320;
   localparam int DIRECTED_KEYS = 20;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 2 * STORE_DEPTH + 10;

   localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

   // one sorted word as the block should emit it
   typedef struct {
      logic [KEY_W-1:0] key;
      logic             last;
      logic             ovf;
   } sorted_word_type;

   // sorted copy of the current batch and the words still owed
   class sort_scoreboard_type;
      logic signed [KEY_W-1:0] held[$];
      bit                      dropped;
      sorted_word_type         owed[$];
      int                      errors;

      // insert an accepted key after all equal ones, or note a drop when full; a last key flushes the batch
      function void note_key(logic [KEY_W-1:0] k, logic l);
         int              pos;
         sorted_word_type w;
         if (held.size() >= STORE_DEPTH) begin
            dropped = 1'b1;
         end else begin
            pos = held.size();
            while (pos > 0 && $signed(k) < held[pos-1]) pos--;
            held.insert(pos, k);
         end
         if (l) begin
            foreach (held[i]) begin
               w.key  = held[i];
               w.last = (i == held.size() - 1);
               w.ovf  = dropped;
               owed.push_back(w);
            end
            held.delete();
            dropped = 1'b0;
         end
      endfunction

      // compare an emitted word with the oldest owed one
      function void check_word(logic [KEY_W-1:0] k, logic l, logic o);
         sorted_word_type w;
         if (owed.size() == 0) begin
            $display("%0t: unexpected word key=%h last=%b ovf=%b", $time, k, l, o);
            errors++;
         end else begin
            w = owed.pop_front();
            if (k !== w.key) begin
               $display("%0t: key mismatch exp=%h act=%h", $time, w.key, k);
               errors++;
            end
            if (l !== w.last) begin
               $display("%0t: last mismatch exp=%b act=%b", $time, w.last, l);
               errors++;
            end
            if (o !== w.ovf) begin
               $display("%0t: overflow mismatch exp=%b act=%b", $time, w.ovf, o);
               errors++;
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [KEY_W-1:0] req_tdata;   // [31:0] key
   logic             req_tlast;   // last_in
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [KEY_W-1:0] rsp_tdata;   // [31:0] sorted_key
   logic             rsp_tlast;   // last_out
   logic [0:0]       rsp_tuser;   // [0] overflow

   sort_scoreboard_type sb = new();
   int                  idle_cycles;

   insertion_sorter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // clock, period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor both streams and run the watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            sb.note_key(req_tdata, req_tlast);
            idle_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_word(rsp_tdata, rsp_tlast, rsp_tuser[0]);
            idle_cycles = 0;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // result side: random stalls per word, with calm stretches
   initial begin
      bit calm;
      int stall;
      calm = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 15) == 0) calm = !calm;
         stall = calm ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   bit send_calm;

   // offer one key after a random gap and hold it until accepted
   task automatic send_key(input logic [KEY_W-1:0] k, input logic l);
      int gap;
      if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= k;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
   endtask

   // random key: full range, a narrow band for ties, or near the extremes
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      case ($urandom_range(0, 3))
         0: k = KEY_W'($urandom_range(0, 15)) - KEY_W'(8);
         1: k = $urandom_range(0, 1) ? KEY_MIN + KEY_W'($urandom_range(0, 3))
                                     : KEY_MAX - KEY_W'($urandom_range(0, 3));
         default: k = $urandom;
      endcase
      return k;
   endfunction

   // one batch of random keys, the final one marked last
   task automatic send_batch(input int count);
      for (int i = 0; i < count; i++) send_key(pick_key(), i == count - 1);
   endtask

   initial begin
      int sent;
      int count;
      send_calm  = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-key batches at zero and at the top of the range
      send_key('0, 1'b1);
      send_key(KEY_MAX, 1'b1);
      // extremes mixed, two equal minimums
      send_key(KEY_MAX, 1'b0);
      send_key(KEY_MIN, 1'b0);
      send_key('1, 1'b0);
      send_key('0, 1'b0);
      send_key(32'd1, 1'b0);
      send_key(KEY_MIN, 1'b1);
      // descending run, every key shifts the whole store
      send_key(32'd50, 1'b0);
      send_key(32'd40, 1'b0);
      send_key(32'd30, 1'b0);
      send_key(32'd20, 1'b0);
      send_key(32'd10, 1'b1);
      // equal keys around a negative one
      send_key(32'd7, 1'b0);
      send_key(32'd7, 1'b0);
      send_key(-32'sd7, 1'b0);
      send_key(32'd7, 1'b1);
      // ascending run, no shifts
      send_key(-32'sd3, 1'b0);
      send_key(-32'sd2, 1'b0);
      send_key(-32'sd1, 1'b1);

      // store overflow, the last key itself dropped
      send_batch(STORE_DEPTH + 2);
      sent = DIRECTED_KEYS + STORE_DEPTH + 2;
      // mostly short batches, a few near or past capacity
      while (sent < RANDOM_KEYS) begin
         if ($urandom_range(0, 9) == 0) count = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 6);
         else count = $urandom_range(1, 12);
         if (count > RANDOM_KEYS - sent) count = RANDOM_KEYS - sent;
         send_batch(count);
         sent += count;
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      // wait for all owed words, then watch for strays
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
